@@ rtl/bcdclk_pkg.sv @@
// bcdclk_pkg: shared types, codes and bcd helpers for the time-of-day clock
`default_nettype none

package bcdclk_pkg;

  // command codes carried by an input word
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  // register offsets
  localparam logic [3:0] OFF_TENTHS   = 4'd8;
  localparam logic [3:0] OFF_SECONDS  = 4'd9;
  localparam logic [3:0] OFF_MINUTES  = 4'd10;
  localparam logic [3:0] OFF_HOURS    = 4'd11;
  localparam logic [3:0] OFF_AL_TENTH = 4'd12;
  localparam logic [3:0] OFF_AL_SEC   = 4'd13;
  localparam logic [3:0] OFF_AL_MIN   = 4'd14;
  localparam logic [3:0] OFF_STATUS   = 4'd15;

  // value returned by undecoded offsets
  localparam logic [7:0] RD_UNDECODED = 8'hFF;

  // top tens digit of each group
  localparam logic [3:0] TOP_MIN_SEC = 4'd5;
  localparam logic [3:0] TOP_HOURS   = 4'd2;
  localparam logic [3:0] LAST_DIGIT  = 4'd9;
  localparam logic [5:0] LAST_HOUR   = 6'h23;

  // packed time: tenths in bits 3:0 up to hours in bits 25:20
  typedef struct packed {
    logic [5:0] hours;
    logic [7:0] minutes;
    logic [7:0] seconds;
    logic [3:0] tenths;
  } time_t;

  // two-digit bcd increment, tens digit wraps to zero above top
  function automatic logic [7:0] bcd_step(input logic [7:0] v, input logic [3:0] top);
    logic [4:0] hi;
    logic [4:0] lo;
    hi = {1'b0, v[7:4]};
    lo = {1'b0, v[3:0]} + 5'd1;
    if (lo > {1'b0, LAST_DIGIT}) begin
      lo = 5'd0;
      hi = hi + 5'd1;
      if (hi > {1'b0, top}) begin
        hi = 5'd0;
      end
    end
    return {hi[3:0], lo[3:0]};
  endfunction

endpackage

`default_nettype wire

@@ rtl/bcdclk_if.sv @@
// bcdclk_if: handshake interfaces for command words and result words
`default_nettype none

interface bcdclk_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [3:0] reg_offset;
  logic [7:0] write_data;

  modport source (output valid, output command, output reg_offset, output write_data,
                  input ready);
  modport sink (input valid, input command, input reg_offset, input write_data,
                output ready);
endinterface

interface bcdclk_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       alarm_pending;

  modport source (output valid, output read_data, output alarm_pending, input ready);
  modport sink (input valid, input read_data, input alarm_pending, output ready);
endinterface

`default_nettype wire

@@ rtl/bcdclk_tick.sv @@
// bcdclk_tick: next time of day after one tenth-second tick
`default_nettype none

module bcdclk_tick
  import bcdclk_pkg::*;
(
  input  time_t cur_i,
  output time_t nxt_o
);

  logic [4:0] tenths_inc;
  logic [7:0] sec_step;
  logic [7:0] min_step;
  logic [7:0] hour_step;

  assign tenths_inc = {1'b0, cur_i.tenths} + 5'd1;
  assign sec_step   = bcd_step(cur_i.seconds, TOP_MIN_SEC);
  assign min_step   = bcd_step(cur_i.minutes, TOP_MIN_SEC);
  assign hour_step  = bcd_step({2'b00, cur_i.hours}, TOP_HOURS);

  // ripple carry through tenths, seconds, minutes and hours
  always_comb begin
    nxt_o = cur_i;
    if (tenths_inc > {1'b0, LAST_DIGIT}) begin
      nxt_o.tenths  = 4'd0;
      nxt_o.seconds = sec_step;
      if (sec_step == 8'd0) begin
        nxt_o.minutes = min_step;
        if (min_step == 8'd0) begin
          if (cur_i.hours == LAST_HOUR) begin
            nxt_o.hours = 6'd0;
          end else begin
            nxt_o.hours = hour_step[5:0];
          end
        end
      end
    end else begin
      nxt_o.tenths = tenths_inc[3:0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/bcd_time_of_day_clock_alarm.sv @@
// bcd_time_of_day_clock_alarm: bcd time-of-day clock with alarm, top level
// flow: a word accepted into the command register executes there and is presented from the result register
// throughput: one word per cycle; the command register and the result register
// each advance every cycle unless the result register is held by the sink
// reset: clears time, alarm, flag, snapshot and all valid bits at once
`default_nettype none

module bcd_time_of_day_clock_alarm
  import bcdclk_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  bcdclk_in_if.sink    in_i,
  bcdclk_out_if.source out_o
);

  // command register
  logic       in_valid_q;
  cmd_e       in_cmd_q;
  logic [3:0] in_off_q;
  logic [7:0] in_data_q;

  // result register
  logic       out_valid_q;
  logic [7:0] out_rd_q;
  logic       out_pend_q;

  // clock state
  time_t      time_q, time_d;
  time_t      alarm_q, alarm_d;
  time_t      snap_q, snap_d;
  logic       armed_q, armed_d;
  logic       hit_q, hit_d;
  logic [7:0] rd_d;

  time_t      tick_nxt;
  logic       fire;

  assign fire       = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || fire;

  // command register load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_cmd_q  <= cmd_e'(in_i.command);
      in_off_q  <= in_i.reg_offset;
      in_data_q <= in_i.write_data;
    end
  end

  bcdclk_tick u_tick (
    .cur_i (time_q),
    .nxt_o (tick_nxt)
  );

  // command execution
  always_comb begin
    time_d  = time_q;
    alarm_d = alarm_q;
    snap_d  = snap_q;
    armed_d = armed_q;
    hit_d   = hit_q;
    rd_d    = 8'd0;
    unique case (in_cmd_q)
      CMD_TICK: begin
        time_d = tick_nxt;
        if (armed_q && (tick_nxt == alarm_q)) begin
          hit_d = 1'b1;
        end
      end
      CMD_READ: begin
        unique case (in_off_q)
          OFF_TENTHS: begin
            snap_d = time_q;
            rd_d   = {4'd0, time_q.tenths};
          end
          OFF_SECONDS:  rd_d = snap_q.seconds;
          OFF_MINUTES:  rd_d = snap_q.minutes;
          OFF_HOURS:    rd_d = {2'd0, snap_q.hours};
          OFF_AL_TENTH: rd_d = {4'd0, alarm_q.tenths};
          OFF_AL_SEC:   rd_d = alarm_q.seconds;
          OFF_AL_MIN:   rd_d = alarm_q.minutes;
          OFF_STATUS:   rd_d = {armed_q, hit_q, 6'd0};
          default:      rd_d = RD_UNDECODED;
        endcase
      end
      CMD_WRITE: begin
        unique case (in_off_q)
          OFF_TENTHS:   time_d.tenths   = in_data_q[3:0];
          OFF_SECONDS:  time_d.seconds  = in_data_q;
          OFF_MINUTES:  time_d.minutes  = in_data_q;
          OFF_HOURS: begin
            time_d.hours = in_data_q[5:0];
            hit_d        = 1'b0;
          end
          OFF_AL_TENTH: alarm_d.tenths  = in_data_q[3:0];
          OFF_AL_SEC:   alarm_d.seconds = in_data_q;
          OFF_AL_MIN:   alarm_d.minutes = in_data_q;
          OFF_STATUS: begin
            armed_d       = in_data_q[7];
            alarm_d.hours = in_data_q[5:0];
          end
          default: ;
        endcase
      end
      CMD_CLEAR: hit_d = 1'b0;
      default: ;
    endcase
  end

  // state update on each executed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q  <= '0;
      alarm_q <= '0;
      snap_q  <= '0;
      armed_q <= 1'b0;
      hit_q   <= 1'b0;
    end else if (fire) begin
      time_q  <= time_d;
      alarm_q <= alarm_d;
      snap_q  <= snap_d;
      armed_q <= armed_d;
      hit_q   <= hit_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_rd_q   <= rd_d;
      out_pend_q <= hit_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.read_data     = out_rd_q;
  assign out_o.alarm_pending = out_pend_q;

`ifndef SYNTHESIS
  // clearing commands leave the flag low
  a_clear_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (in_cmd_q == CMD_CLEAR) |=> !hit_q)
    else $error("alarm flag set after clear command");

  a_hours_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (in_cmd_q == CMD_WRITE) && (in_off_q == OFF_HOURS) |=> !hit_q)
    else $error("alarm flag set after hours write");

  // only reads return data
  a_nonread_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (in_cmd_q != CMD_READ) |=> out_valid_q && (out_rd_q == 8'd0))
    else $error("nonzero read data for a non-read word");

  // state moves only when a word executes
  a_time_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(time_q) && $stable(hit_q))
    else $error("clock state changed without a word");

  // result flag mirrors the state flag
  a_pend_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_pend_q == hit_q)
    else $error("alarm_pending differs from flag");
`endif

endmodule

`default_nettype wire

@@ test/tb_bcd_time_of_day_clock_alarm.sv @@
// tb_bcd_time_of_day_clock_alarm: self-checking testbench for the bcd time-of-day clock
module tb_bcd_time_of_day_clock_alarm;
  import bcdclk_pkg::*;

  // offsets outside the decoded range
  localparam logic [3:0] UNDEC_LOW  = 4'd0;
  localparam logic [3:0] UNDEC_HIGH = 4'd7;
  // status bits and write masks
  localparam logic [7:0] STAT_ARMED = 8'h80;
  localparam logic [7:0] STAT_HIT   = 8'h40;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned RANDOM_ITEMS   = 1000;
  localparam int unsigned TOTAL_ITEMS    = 1150;

  typedef struct packed {
    logic [7:0] read_data;
    logic       alarm_pending;
  } result_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bcdclk_in_if  cmd_if ();
  bcdclk_out_if res_if ();

  bcd_time_of_day_clock_alarm DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (cmd_if.sink),
    .out_o  (res_if.source)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted clock and alarm state
  time_t      tod_now;
  time_t      tod_snap;
  logic [3:0] al_tenths;
  logic [7:0] al_seconds;
  logic [7:0] al_minutes;
  logic [5:0] al_hours;
  logic       al_armed;
  logic       al_hit;

  result_word_t expected_results[$];
  result_word_t exp_word;
  int unsigned  words_sent = 0;
  int unsigned  mismatches = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  stall_left = 0;
  bit           idle_on = 1'b1;

  // two-digit bcd increment with the tens digit wrapping above top
  function automatic logic [7:0] bcd_inc(logic [7:0] v, logic [3:0] top);
    logic [3:0] tens;
    logic [3:0] ones;
    tens = v[7:4];
    ones = v[3:0];
    if (ones >= 4'd9) begin
      ones = 4'd0;
      tens = (tens >= top) ? 4'd0 : tens + 4'd1;
    end else begin
      ones = ones + 4'd1;
    end
    return {tens, ones};
  endfunction

  // one tenth-second tick, carries ripple only when a group lands on zero
  task automatic advance_clock();
    logic [7:0] hrs;
    if (tod_now.tenths >= 4'd9) begin
      tod_now.tenths = 4'd0;
      tod_now.seconds = bcd_inc(tod_now.seconds, TOP_MIN_SEC);
      if (tod_now.seconds == 8'h00) begin
        tod_now.minutes = bcd_inc(tod_now.minutes, TOP_MIN_SEC);
        if (tod_now.minutes == 8'h00) begin
          if (tod_now.hours == LAST_HOUR) begin
            tod_now.hours = 6'h00;
          end else begin
            hrs = bcd_inc({2'b00, tod_now.hours}, TOP_HOURS);
            tod_now.hours = hrs[5:0];
          end
        end
      end
    end else begin
      tod_now.tenths = tod_now.tenths + 4'd1;
    end
    if (al_armed && tod_now.tenths == al_tenths && tod_now.seconds == al_seconds &&
        tod_now.minutes == al_minutes && tod_now.hours == al_hours) begin
      al_hit = 1'b1;
    end
  endtask

  // register read side, offset 8 latches the snapshot
  function automatic logic [7:0] read_register(logic [3:0] off);
    case (off)
      OFF_TENTHS: begin
        tod_snap = tod_now;
        return {4'h0, tod_snap.tenths};
      end
      OFF_SECONDS:  return tod_snap.seconds;
      OFF_MINUTES:  return tod_snap.minutes;
      OFF_HOURS:    return {2'b00, tod_snap.hours};
      OFF_AL_TENTH: return {4'h0, al_tenths};
      OFF_AL_SEC:   return al_seconds;
      OFF_AL_MIN:   return al_minutes;
      OFF_STATUS:   return (al_armed ? STAT_ARMED : 8'h00) | (al_hit ? STAT_HIT : 8'h00);
      default:      return RD_UNDECODED;
    endcase
  endfunction

  // register write side
  task automatic write_register(logic [3:0] off, logic [7:0] d);
    case (off)
      OFF_TENTHS:   tod_now.tenths = d[3:0];
      OFF_SECONDS:  tod_now.seconds = d;
      OFF_MINUTES:  tod_now.minutes = d;
      OFF_HOURS: begin
        tod_now.hours = d[5:0];
        al_hit = 1'b0;
      end
      OFF_AL_TENTH: al_tenths = d[3:0];
      OFF_AL_SEC:   al_seconds = d;
      OFF_AL_MIN:   al_minutes = d;
      OFF_STATUS: begin
        al_armed = d[7];
        al_hours = d[5:0];
      end
      default: ;
    endcase
  endtask

  // expected result word for one accepted command word
  task automatic predict_clock_word(cmd_e c, logic [3:0] off, logic [7:0] d,
                                    output result_word_t w);
    w.read_data = 8'h00;
    case (c)
      CMD_TICK:  advance_clock();
      CMD_READ:  w.read_data = read_register(off);
      CMD_WRITE: write_register(off, d);
      default:   al_hit = 1'b0;
    endcase
    w.alarm_pending = al_hit;
  endtask

  // send one command word, with a random gap before it while idling is on
  task automatic send_word(cmd_e c, logic [3:0] off, logic [7:0] d);
    int unsigned gap;
    result_word_t w;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.command <= c;
    cmd_if.reg_offset <= off;
    cmd_if.write_data <= d;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    predict_clock_word(c, off, d, w);
    expected_results.push_back(w);
    words_sent++;
  endtask

  task automatic send_tick();
    send_word(CMD_TICK, 4'($urandom), 8'($urandom));
  endtask

  task automatic send_read(logic [3:0] off);
    send_word(CMD_READ, off, 8'($urandom));
  endtask

  task automatic send_write(logic [3:0] off, logic [7:0] d);
    send_word(CMD_WRITE, off, d);
  endtask

  // random valid bcd values
  function automatic logic [7:0] rand_bcd_min_sec();
    return {4'($urandom_range(0, 5)), 4'($urandom_range(0, 9))};
  endfunction

  function automatic logic [5:0] rand_bcd_hours();
    logic [1:0] tens;
    tens = 2'($urandom_range(0, 2));
    return {tens, 4'($urandom_range(0, (tens == 2'd2) ? 3 : 9))};
  endfunction

  // writes to undecoded offsets are dropped and reads return all ones
  task automatic test_undecoded_offsets();
    send_write(UNDEC_HIGH, 8'hFF);
    send_read(UNDEC_LOW);
    send_read(UNDEC_HIGH);
  endtask

  // non-bcd tenths and the full 23:59:59 rollover to midnight
  task automatic test_midnight_rollover();
    send_write(OFF_TENTHS, 8'hFF);
    send_write(OFF_SECONDS, 8'h59);
    send_write(OFF_MINUTES, 8'h59);
    send_write(OFF_HOURS, 8'h23);
    send_tick();
    send_read(OFF_TENTHS);
    send_read(OFF_SECONDS);
    send_read(OFF_MINUTES);
    send_read(OFF_HOURS);
  endtask

  // alarm match, clear by command and by an hours write, disarm
  task automatic test_alarm_match();
    send_write(OFF_AL_TENTH, 8'hF1);
    send_write(OFF_AL_SEC, 8'h00);
    send_write(OFF_AL_MIN, 8'h00);
    send_write(OFF_STATUS, STAT_ARMED);
    send_tick();
    send_read(OFF_STATUS);
    send_word(CMD_CLEAR, OFF_STATUS, 8'h00);
    send_write(OFF_TENTHS, 8'h00);
    send_tick();
    send_write(OFF_HOURS, 8'h00);
    send_read(OFF_AL_TENTH);
    send_read(OFF_AL_SEC);
    send_read(OFF_AL_MIN);
    send_write(OFF_STATUS, 8'h7F);
    send_read(OFF_STATUS);
  endtask

  // set a time, arm an alarm a few ticks ahead and run into it
  task automatic alarm_run();
    logic [7:0] ss;
    logic [7:0] mm;
    logic [5:0] hh;
    int unsigned k;
    int unsigned t0;
    ss = rand_bcd_min_sec();
    mm = rand_bcd_min_sec();
    hh = rand_bcd_hours();
    k = $urandom_range(1, 6);
    t0 = $urandom_range(0, 9 - k);
    send_write(OFF_TENTHS, {4'($urandom), 4'(t0)});
    send_write(OFF_SECONDS, ss);
    send_write(OFF_MINUTES, mm);
    send_write(OFF_HOURS, {2'($urandom), hh});
    send_write(OFF_AL_TENTH, {4'($urandom), 4'(t0 + k)});
    send_write(OFF_AL_SEC, ss);
    send_write(OFF_AL_MIN, mm);
    send_write(OFF_STATUS, {1'b1, 1'($urandom), hh});
    repeat (k + $urandom_range(0, 3)) send_tick();
    send_read(OFF_STATUS);
    send_read(OFF_TENTHS);
    send_read(OFF_HOURS);
    if ($urandom_range(0, 1) == 0) begin
      send_word(CMD_CLEAR, 4'($urandom), 8'($urandom));
    end else begin
      send_write(OFF_HOURS, {2'($urandom), rand_bcd_hours()});
    end
  endtask

  // park the time just short of a group rollover and tick through it
  task automatic rollover_run();
    send_write(OFF_TENTHS, 8'h09);
    send_write(OFF_SECONDS, ($urandom_range(0, 2) != 0) ? 8'h59 : rand_bcd_min_sec());
    send_write(OFF_MINUTES, ($urandom_range(0, 1) != 0) ? 8'h59 : 8'($urandom));
    send_write(OFF_HOURS, ($urandom_range(0, 1) != 0) ? 8'h23 : 8'($urandom));
    repeat ($urandom_range(1, 12)) send_tick();
    send_read(OFF_TENTHS);
    send_read(OFF_SECONDS);
    send_read(OFF_MINUTES);
    send_read(OFF_HOURS);
  endtask

  // a string of ticks with status polls in between
  task automatic tick_run();
    repeat ($urandom_range(5, 30)) begin
      if ($urandom_range(0, 5) == 0) begin
        send_read(OFF_STATUS);
      end else begin
        send_tick();
      end
    end
  endtask

  // fully random words, non-bcd data and undecoded offsets included
  task automatic noise_run();
    repeat ($urandom_range(4, 12)) begin
      send_word(cmd_e'($urandom_range(0, 3)), 4'($urandom), 8'($urandom));
    end
  endtask

  task automatic random_mix(int unsigned target);
    while (words_sent < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2: alarm_run();
        3, 4:    rollover_run();
        5, 6:    tick_run();
        default: noise_run();
      endcase
    end
  endtask

  // random traffic with gaps and stalls on both sides
  task automatic test_random_traffic();
    idle_on = 1'b1;
    random_mix(RANDOM_ITEMS);
  endtask

  // back-to-back traffic at full rate with no idling at all
  task automatic test_full_rate();
    idle_on = 1'b0;
    random_mix(TOTAL_ITEMS);
  endtask

  // result sink ready with random stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_if.ready <= 1'b0;
    end else if (idle_on && res_if.ready && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 18);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word: read_data %h alarm_pending %b",
               res_if.read_data, res_if.alarm_pending);
        mismatches++;
      end else begin
        exp_word = expected_results.pop_front();
        if (res_if.read_data !== exp_word.read_data) begin
          $error("read_data mismatch: expected %h, actual %h",
                 exp_word.read_data, res_if.read_data);
          mismatches++;
        end
        if (res_if.alarm_pending !== exp_word.alarm_pending) begin
          $error("alarm_pending mismatch: expected %b, actual %b",
                 exp_word.alarm_pending, res_if.alarm_pending);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // reset, tests in turn, drain and verdict
  initial begin
    cmd_if.valid <= 1'b0;
    cmd_if.command <= CMD_TICK;
    cmd_if.reg_offset <= UNDEC_LOW;
    cmd_if.write_data <= 8'h00;
    tod_now = '0;
    tod_snap = '0;
    al_tenths = '0;
    al_seconds = '0;
    al_minutes = '0;
    al_hours = '0;
    al_armed = 1'b0;
    al_hit = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_undecoded_offsets();
    test_midnight_rollover();
    test_alarm_match();
    test_random_traffic();
    test_full_rate();

    cmd_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
